// ===== rtl/core/keyframe_linear_interpolator_defines.svh =====
// assertion macros shared by the keyframe interpolator modules
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KLI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kli_pkg.sv =====
// types, codes and microprogram of the keyframe interpolator
package kli_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PADDR_W = 3;
    localparam int KC_W    = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic            REG_KEY_COUNT   = 1'b0;
    localparam logic [KC_W-1:0] KEY_COUNT_RESET = 7'd1;

    localparam logic [3:0] DIV_LAST  = 4'd15;
    localparam logic [1:0] COMP_LAST = 2'd2;

    typedef logic [3:0] t_kli_op;
    localparam t_kli_op OP_NOP      = 4'd0;
    localparam t_kli_op OP_ACCEPT   = 4'd1;
    localparam t_kli_op OP_ADDR_INC = 4'd2;
    localparam t_kli_op OP_CHK0     = 4'd3;
    localparam t_kli_op OP_SCAN     = 4'd4;
    localparam t_kli_op OP_DIV_INIT = 4'd5;
    localparam t_kli_op OP_DIV_STEP = 4'd6;
    localparam t_kli_op OP_MUL      = 4'd7;
    localparam t_kli_op OP_ADD      = 4'd8;
    localparam t_kli_op OP_OUT      = 4'd9;

    typedef logic [3:0] t_kli_cond;
    localparam t_kli_cond C_NEVER       = 4'd0;
    localparam t_kli_cond C_ALWAYS      = 4'd1;
    localparam t_kli_cond C_QSTART      = 4'd2;
    localparam t_kli_cond C_EARLY       = 4'd3;
    localparam t_kli_cond C_LAST_MISS   = 4'd4;
    localparam t_kli_cond C_MISS        = 4'd5;
    localparam t_kli_cond C_BELOW_START = 4'd6;
    localparam t_kli_cond C_DIV_MORE    = 4'd7;
    localparam t_kli_cond C_COMP_MORE   = 4'd8;
    localparam t_kli_cond C_OUT_FREE    = 4'd9;

    typedef logic [3:0] t_kli_step;
    localparam t_kli_step S_IDLE = 4'd0;
    localparam t_kli_step S_LAT  = 4'd1;
    localparam t_kli_step S_CHK0 = 4'd2;
    localparam t_kli_step S_SCAN = 4'd3;
    localparam t_kli_step S_DIVI = 4'd4;
    localparam t_kli_step S_DIVS = 4'd5;
    localparam t_kli_step S_MUL  = 4'd6;
    localparam t_kli_step S_ADD  = 4'd7;
    localparam t_kli_step S_OUT  = 4'd8;

    typedef struct packed {
        t_kli_op   op;
        t_kli_cond jcond;
        t_kli_step jtgt;
        t_kli_cond hcond;
    } t_kli_uword;

    typedef struct packed {
        logic qstart;
        logic early;
        logic last_miss;
        logic miss;
        logic below_start;
        logic div_more;
        logic comp_more;
        logic out_free;
    } t_kli_status;

    typedef struct packed {
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } t_kli_key;

    // jump taken first, then hold, else fall through to the next step
    function automatic t_kli_uword kli_rom(input t_kli_step step);
        t_kli_uword w;
        case (step)
            S_IDLE:  w = '{op: OP_ACCEPT,   jcond: C_QSTART,      jtgt: S_LAT,  hcond: C_ALWAYS};
            S_LAT:   w = '{op: OP_ADDR_INC, jcond: C_NEVER,       jtgt: S_IDLE, hcond: C_NEVER};
            S_CHK0:  w = '{op: OP_CHK0,     jcond: C_EARLY,       jtgt: S_OUT,  hcond: C_NEVER};
            S_SCAN:  w = '{op: OP_SCAN,     jcond: C_LAST_MISS,   jtgt: S_OUT,  hcond: C_MISS};
            S_DIVI:  w = '{op: OP_DIV_INIT, jcond: C_BELOW_START, jtgt: S_OUT,  hcond: C_NEVER};
            S_DIVS:  w = '{op: OP_DIV_STEP, jcond: C_NEVER,       jtgt: S_IDLE, hcond: C_DIV_MORE};
            S_MUL:   w = '{op: OP_MUL,      jcond: C_NEVER,       jtgt: S_IDLE, hcond: C_NEVER};
            S_ADD:   w = '{op: OP_ADD,      jcond: C_COMP_MORE,   jtgt: S_MUL,  hcond: C_NEVER};
            S_OUT:   w = '{op: OP_OUT,      jcond: C_OUT_FREE,    jtgt: S_IDLE, hcond: C_ALWAYS};
            default: w = '{op: OP_NOP,      jcond: C_ALWAYS,      jtgt: S_IDLE, hcond: C_NEVER};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/kli_store.sv =====
// key memory: time and three values per slot, one write and one registered read port
module kli_store #(
    parameter int AW
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  kli_pkg::t_kli_key i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output kli_pkg::t_kli_key o_rdata
);
    import kli_pkg::*;

    localparam int DEPTH = 1 << AW;

    t_kli_key r_mem [DEPTH];
    t_kli_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/kli_seq.sv =====
// microcode sequencer: step counter, control rom and jump logic
`include "keyframe_linear_interpolator_defines.svh"

module kli_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kli_pkg::t_kli_status i_status,
    output kli_pkg::t_kli_op     o_op
);
    import kli_pkg::*;

    t_kli_step  r_step;
    t_kli_step  n_step;
    t_kli_uword uw;
    logic       jmp;
    logic       hold;

    function automatic logic cond_true(input t_kli_cond c, input t_kli_status s);
        logic v;
        case (c)
            C_NEVER:       v = 1'b0;
            C_ALWAYS:      v = 1'b1;
            C_QSTART:      v = s.qstart;
            C_EARLY:       v = s.early;
            C_LAST_MISS:   v = s.last_miss;
            C_MISS:        v = s.miss;
            C_BELOW_START: v = s.below_start;
            C_DIV_MORE:    v = s.div_more;
            C_COMP_MORE:   v = s.comp_more;
            C_OUT_FREE:    v = s.out_free;
            default:       v = 1'b0;
        endcase
        return v;
    endfunction

    always_comb begin
        uw   = kli_rom(r_step);
        jmp  = cond_true(uw.jcond, i_status);
        hold = cond_true(uw.hcond, i_status);
        if (jmp) begin
            n_step = uw.jtgt;
        end else if (hold) begin
            n_step = r_step;
        end else begin
            n_step = t_kli_step'(r_step + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op = uw.op;

    `KLI_ASSERT_IMPL(a_add_after_mul, o_op == OP_ADD, $past(o_op) == OP_MUL,
        "blend add without a preceding multiply")
    `KLI_ASSERT_NEXT(a_out_to_idle, (o_op == OP_OUT) && i_status.out_free,
        o_op == OP_ACCEPT, "sequencer did not return to idle after result load")

endmodule

// ===== rtl/core/kli_dp.sv =====
// datapath: config register, key scan, 16-step divider, shared blend multiplier, output register
`include "keyframe_linear_interpolator_defines.svh"

module kli_dp #(
    parameter int MAX_KEYS,
    parameter int AW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kli_pkg::t_kli_op              i_op,
    output kli_pkg::t_kli_status          o_status,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [5:0]                    i_key_index,
    input  logic [31:0]                   i_key_time,
    input  logic signed [31:0]            i_key_value_x,
    input  logic signed [31:0]            i_key_value_y,
    input  logic signed [31:0]            i_key_value_z,
    input  logic [31:0]                   i_query_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_result_x,
    output logic signed [31:0]            o_result_y,
    output logic signed [31:0]            o_result_z,
    output logic                          o_out_of_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kli_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic                          o_st_we,
    output logic [AW-1:0]                 o_st_waddr,
    output kli_pkg::t_kli_key             o_st_wdata,
    output logic [AW-1:0]                 o_st_raddr,
    input  kli_pkg::t_kli_key             i_st_rdata
);
    import kli_pkg::*;

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int KW = (CW > KC_W) ? CW : KC_W;
    localparam int IW = (CW > 6) ? CW : 6;

    logic [KC_W-1:0]   r_key_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_q;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_j;
    t_kli_key          r_a;
    t_kli_key          r_b;
    logic              r_flag;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_len;
    logic [FRAC_W-1:0] r_fac;
    logic [3:0]        r_cnt;
    logic [1:0]        r_comp;
    logic signed [49:0] r_prod;
    logic [DATA_W-1:0] r_res_x;
    logic [DATA_W-1:0] r_res_y;
    logic [DATA_W-1:0] r_res_z;
    logic              r_res_flag;

    logic              in_accept;
    logic              cfg_wr;
    logic [KW-1:0]     kc_ext;
    logic [KW-1:0]     n_keys;
    logic [AW-1:0]     last_idx;
    logic              single;
    logic              found;
    logic              out_free;
    logic [DATA_W-1:0] sel_a;
    logic [DATA_W-1:0] sel_b;
    logic signed [32:0] diff;
    logic signed [16:0] fac_s;
    logic signed [49:0] prod;
    logic [DATA_W-1:0] blend;
    logic [DATA_W:0]   rem2;
    logic [DATA_W:0]   rem_sub;
    logic              rem_ge;

    assign o_in_stall = (i_op != OP_ACCEPT);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_st_we    = in_accept && (i_command == CMD_WRITE) &&
                        (IW'(i_key_index) < IW'(MAX_KEYS));
    assign o_st_waddr = AW'(i_key_index);
    assign o_st_wdata = '{t: i_key_time, x: i_key_value_x, y: i_key_value_y, z: i_key_value_z};
    assign o_st_raddr = r_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_KEY_COUNT);
    assign prdata = (paddr[PADDR_W-1] == REG_KEY_COUNT) ? 32'(r_key_count) : '0;

    assign kc_ext = KW'(r_key_count);
    always_comb begin
        if (kc_ext == '0) begin
            n_keys = KW'(1);
        end else if (kc_ext > KW'(MAX_KEYS)) begin
            n_keys = KW'(MAX_KEYS);
        end else begin
            n_keys = kc_ext;
        end
    end
    assign last_idx = AW'(n_keys - KW'(1));
    assign single   = (n_keys == KW'(1));

    assign found    = r_q < i_st_rdata.t;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status = '{
        qstart:      in_accept && (i_command == CMD_QUERY),
        early:       single || found,
        last_miss:   !found && (r_j == last_idx),
        miss:        !found,
        below_start: r_q < r_a.t,
        div_more:    r_cnt != DIV_LAST,
        comp_more:   r_comp != COMP_LAST,
        out_free:    out_free
    };

    always_comb begin
        case (r_comp)
            2'd0: begin
                sel_a = r_a.x;
                sel_b = r_b.x;
            end
            2'd1: begin
                sel_a = r_a.y;
                sel_b = r_b.y;
            end
            default: begin
                sel_a = r_a.z;
                sel_b = r_b.z;
            end
        endcase
    end

    assign diff  = $signed({sel_b[DATA_W-1], sel_b}) - $signed({sel_a[DATA_W-1], sel_a});
    assign fac_s = $signed({1'b0, r_fac});
    assign prod  = diff * fac_s;
    // floor of the scaled step, low word is enough since the sum stays in range
    assign blend = sel_a + r_prod[FRAC_W+DATA_W-1:FRAC_W];

    assign rem2    = {r_rem, 1'b0};
    assign rem_sub = rem2 - {1'b0, r_len};
    assign rem_ge  = rem2 >= {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_key_count <= pwdata[KC_W-1:0];
            end
            if ((i_op == OP_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ACCEPT: begin
                if (in_accept && (i_command == CMD_QUERY)) begin
                    r_q    <= i_query_time;
                    r_addr <= '0;
                end
            end
            OP_ADDR_INC: begin
                r_addr <= r_addr + AW'(1);
                r_j    <= '0;
            end
            OP_CHK0: begin
                r_a    <= i_st_rdata;
                r_flag <= !single && found;
                r_addr <= r_addr + AW'(1);
                r_j    <= AW'(1);
            end
            OP_SCAN: begin
                if (found) begin
                    r_b    <= i_st_rdata;
                    r_flag <= 1'b0;
                end else begin
                    r_a    <= i_st_rdata;
                    r_flag <= r_q > i_st_rdata.t;
                end
                r_addr <= r_addr + AW'(1);
                r_j    <= r_j + AW'(1);
            end
            OP_DIV_INIT: begin
                r_rem  <= r_q - r_a.t;
                r_len  <= r_b.t - r_a.t;
                r_fac  <= '0;
                r_cnt  <= '0;
                r_comp <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
                r_fac <= {r_fac[FRAC_W-2:0], rem_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            OP_MUL: begin
                r_prod <= prod;
            end
            OP_ADD: begin
                case (r_comp)
                    2'd0:    r_a.x <= blend;
                    2'd1:    r_a.y <= blend;
                    default: r_a.z <= blend;
                endcase
                r_comp <= r_comp + 2'd1;
            end
            OP_OUT: begin
                if (out_free) begin
                    r_res_x    <= r_a.x;
                    r_res_y    <= r_a.y;
                    r_res_z    <= r_a.z;
                    r_res_flag <= r_flag;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_x     = r_res_x;
    assign o_result_y     = r_res_y;
    assign o_result_z     = r_res_z;
    assign o_out_of_range = r_res_flag;

    `KLI_ASSERT_IMPL(a_rem_below_len, i_op == OP_DIV_STEP, r_rem < r_len,
        "divider remainder not below segment length")
    `KLI_ASSERT_IMPL(a_scan_in_range, i_op == OP_SCAN, r_j <= last_idx,
        "key scan ran past the last key")
    `KLI_ASSERT_IMPL(a_out_from_out, !$past(r_out_valid) && r_out_valid,
        $past(i_op) == OP_OUT, "result register loaded outside the output step")

endmodule

// ===== rtl/core/keyframe_linear_interpolator.sv =====
// top level of the keyframe linear interpolator
// input channel (i_in_valid / o_in_stall) takes one transaction at a time: command 0
//   writes a key (time, x, y, z) into slot key_index, command 1 queries at query_time
// output channel (o_out_valid / i_out_stall) carries one result per query, none per write
// a write is taken without leaving idle; the block is ready again on the next cycle
// query path from acceptance to o_out_valid:
//   a single key or a time before the first key goes straight to the output step
//   the scan, one key per cycle, goes to the output step when it runs off the end
//   a query inside a segment gets its factor from a restoring divider, then three
//   multiply/add pairs; a segment start above the query time skips both
// the next query can be accepted in the cycle after the result is loaded
// the result register frees the sequencer: a stalled result only blocks the
//   next query at its output step, and holds its value until taken
// key_count is written through the apb port at byte address 0; the user must do so
// only while idle, and the block does not enforce it
// reset sets key_count to 1 and empties the output; key slots stay undefined
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [5:0]                  i_key_index,
    input  logic [31:0]                 i_key_time,
    input  logic signed [31:0]          i_key_value_x,
    input  logic signed [31:0]          i_key_value_y,
    input  logic signed [31:0]          i_key_value_z,
    input  logic [31:0]                 i_query_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_result_x,
    output logic signed [31:0]          o_result_y,
    output logic signed [31:0]          o_result_z,
    output logic                        o_out_of_range,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kli_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import kli_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    t_kli_op     op;
    t_kli_status status;
    logic        st_we;
    logic [AW-1:0] st_waddr;
    t_kli_key    st_wdata;
    logic [AW-1:0] st_raddr;
    t_kli_key    st_rdata;

    kli_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op)
    );

    kli_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    kli_dp #(
        .MAX_KEYS (MAX_KEYS),
        .AW       (AW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_status       (status),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_key_index    (i_key_index),
        .i_key_time     (i_key_time),
        .i_key_value_x  (i_key_value_x),
        .i_key_value_y  (i_key_value_y),
        .i_key_value_z  (i_key_value_z),
        .i_query_time   (i_query_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_x     (o_result_x),
        .o_result_y     (o_result_y),
        .o_result_z     (o_result_z),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_st_we        (st_we),
        .o_st_waddr     (st_waddr),
        .o_st_wdata     (st_wdata),
        .o_st_raddr     (st_raddr),
        .i_st_rdata     (st_rdata)
    );

endmodule

// ===== verif/kli_result_checker.sv =====
`timescale 1ns / 100ps
// checker for the keyframe interpolator: mirrors keys and key count, predicts and compares results
module kli_result_checker #(
    parameter int MAX_KEYS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_command,
    input  logic [5:0]                  i_key_index,
    input  logic [31:0]                 i_key_time,
    input  logic signed [31:0]          i_key_value_x,
    input  logic signed [31:0]          i_key_value_y,
    input  logic signed [31:0]          i_key_value_z,
    input  logic [31:0]                 i_query_time,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [31:0]          i_result_x,
    input  logic signed [31:0]          i_result_y,
    input  logic signed [31:0]          i_result_z,
    input  logic                        i_out_of_range,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [kli_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          o_mismatch_count,
    output int                          o_results_outstanding
);
    import kli_pkg::*;

    localparam logic [PADDR_W-1:0] KEY_COUNT_ADDR = PADDR_W'(4 * REG_KEY_COUNT);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               clamped;
    } interp_result_t;

    logic [31:0]     track_time [MAX_KEYS];
    logic [31:0]     track_x [MAX_KEYS];
    logic [31:0]     track_y [MAX_KEYS];
    logic [31:0]     track_z [MAX_KEYS];
    logic [KC_W-1:0] key_count_reg;
    interp_result_t  expected_results [$];

    // floor of span * frac / 2^16 with the span exact, so the sum stays between the endpoints
    function automatic logic [31:0] lerp_component(input logic [31:0] seg_start,
                                                   input logic [31:0] seg_stop,
                                                   input logic [15:0] frac);
        longint base, span;
        base = longint'($signed(seg_start));
        span = longint'($signed(seg_stop)) - base;
        return 32'(base + ((span * longint'(frac)) >>> 16));
    endfunction

    function automatic interp_result_t interpolate_at(input logic [31:0] qt);
        int             n, k;
        bit             found;
        logic [15:0]    frac;
        logic [47:0]    scaled;
        interp_result_t r;
        n = (key_count_reg == 0) ? 1 : (key_count_reg > MAX_KEYS) ? MAX_KEYS : key_count_reg;
        k = 0;
        found = 1'b0;
        frac = '0;
        r.clamped = 1'b0;
        if (n > 1) begin
            if (qt < track_time[0]) begin
                r.clamped = 1'b1;
            end else begin
                for (int i = 0; i + 1 < n && !found; i++) begin
                    if (qt < track_time[i + 1]) begin
                        k = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    k = n - 1;
                    r.clamped = (qt > track_time[n - 1]);
                end else if (qt >= track_time[k]) begin
                    scaled = {qt - track_time[k], 16'h0000};
                    frac = 16'(scaled / (track_time[k + 1] - track_time[k]));
                end
            end
        end
        if (found) begin
            r.x = lerp_component(track_x[k], track_x[k + 1], frac);
            r.y = lerp_component(track_y[k], track_y[k + 1], frac);
            r.z = lerp_component(track_z[k], track_z[k + 1], frac);
        end else begin
            r.x = track_x[k];
            r.y = track_y[k];
            r.z = track_z[k];
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", field, want, got);
            o_mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : track_and_check
        interp_result_t want;
        if (!i_rst_n) begin
            key_count_reg = KEY_COUNT_RESET;
            expected_results.delete();
            o_mismatch_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == KEY_COUNT_ADDR) begin
                key_count_reg = pwdata[KC_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: x %h y %h z %h out_of_range %b",
                           i_result_x, i_result_y, i_result_z, i_out_of_range);
                    o_mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_x", want.x, i_result_x);
                    compare_field("result_y", want.y, i_result_y);
                    compare_field("result_z", want.z, i_result_z);
                    compare_field("out_of_range", 32'(want.clamped), 32'(i_out_of_range));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_WRITE) begin
                    track_time[i_key_index] = i_key_time;
                    track_x[i_key_index] = i_key_value_x;
                    track_y[i_key_index] = i_key_value_y;
                    track_z[i_key_index] = i_key_value_z;
                end else begin
                    expected_results = {expected_results, interpolate_at(i_query_time)};
                end
            end
        end
        o_results_outstanding = expected_results.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// top of the keyframe interpolator testbench: clock, reset, stimulus and verdict
module testbench;
    import kli_pkg::*;

    localparam int MAX_KEYS      = 64;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 120;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LONG_HOLD     = 300;
    localparam logic [PADDR_W-1:0] KEY_COUNT_ADDR = PADDR_W'(4 * REG_KEY_COUNT);

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               command = CMD_WRITE;
    logic [5:0]         key_index = '0;
    logic [31:0]        key_time = '0;
    logic signed [31:0] key_x = '0;
    logic signed [31:0] key_y = '0;
    logic signed [31:0] key_z = '0;
    logic [31:0]        query_time = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               out_of_range;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 mismatch_count;
    int                 results_outstanding;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_requests = 0;
    int                 holds_served = 0;
    int                 hold_left = 0;
    int                 items_sent = 0;
    int                 key_limit = 1;
    logic [31:0]        key_times [MAX_KEYS];

    keyframe_linear_interpolator #(
        .MAX_KEYS(MAX_KEYS)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_command(command),
        .i_key_index(key_index),
        .i_key_time(key_time),
        .i_key_value_x(key_x),
        .i_key_value_y(key_y),
        .i_key_value_z(key_z),
        .i_query_time(query_time),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_result_x(result_x),
        .o_result_y(result_y),
        .o_result_z(result_z),
        .o_out_of_range(out_of_range),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    kli_result_checker #(
        .MAX_KEYS(MAX_KEYS)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_command(command),
        .i_key_index(key_index),
        .i_key_time(key_time),
        .i_key_value_x(key_x),
        .i_key_value_y(key_y),
        .i_key_value_z(key_z),
        .i_query_time(query_time),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_result_x(result_x),
        .i_result_y(result_y),
        .i_result_z(result_z),
        .i_out_of_range(out_of_range),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .o_mismatch_count(mismatch_count),
        .o_results_outstanding(results_outstanding)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] key_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(8));
            default: return $urandom;
        endcase
    endfunction

    // entered and left just after a falling edge
    task automatic send_item(input logic cmd, input logic [5:0] slot, input logic [31:0] t,
                             input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic [31:0] q);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        key_index <= slot;
        key_time <= t;
        key_x <= x;
        key_y <= y;
        key_z <= z;
        query_time <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_key(input logic [5:0] slot, input logic [31:0] t, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        key_times[slot] = t;
        send_item(CMD_WRITE, slot, t, x, y, z, $urandom);
    endtask

    task automatic query_at(input logic [31:0] q);
        send_item(CMD_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom, q);
    endtask

    // waits for every outstanding result, then writes key_count over apb
    task automatic set_key_count(input logic [KC_W-1:0] v);
        in_valid <= 1'b0;
        while (results_outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= KEY_COUNT_ADDR;
        pwdata <= {25'($urandom), v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        key_limit = (v == 0) ? 1 : (v > MAX_KEYS) ? MAX_KEYS : v;
    endtask

    // non-decreasing key times from a random base, occasionally scrambled
    task automatic load_track(input int n, input bit scramble);
        longint unsigned t, room;
        logic [31:0]     kt;
        t = ($urandom_range(3) == 0) ? 0 : $urandom_range(32'hC000_0000);
        room = (64'hFFFF_FFFF - t) / n;
        for (int slot = 0; slot < n; slot++) begin
            kt = (scramble && $urandom_range(2) == 0) ? $urandom : 32'(t);
            write_key(6'(slot), kt, key_value(), key_value(), key_value());
            case ($urandom_range(7))
                0: t += $urandom_range(2);
                1: t += $urandom_range(4096, 1);
                default: t += $urandom_range(32'(room));
            endcase
        end
    endtask

    task automatic random_query();
        int              seg;
        logic [31:0]     q, first_t, last_t;
        longint unsigned lo, hi;
        first_t = key_times[0];
        last_t = key_times[key_limit - 1];
        seg = (key_limit > 1) ? $urandom_range(key_limit - 2) : 0;
        lo = key_times[seg];
        hi = key_times[seg + 1];
        q = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                if (key_limit > 1 && hi >= lo) q = 32'(lo + longint'($urandom) % (hi - lo + 1));
            end
            6: q = key_times[$urandom_range(key_limit - 1)];
            7: if (first_t != 0) q = $urandom_range(first_t - 1);
            8: if (last_t != 32'hFFFF_FFFF) q = $urandom_range(32'hFFFF_FFFF, last_t + 1);
            default: ;
        endcase
        query_at(q);
    endtask

    task automatic run_round(input bit long_hold);
        logic [KC_W-1:0] v;
        case ($urandom_range(15))
            0: v = 0;
            1: v = 1;
            2: v = MAX_KEYS;
            3: v = 127;
            4: v = $urandom_range(127, MAX_KEYS + 1);
            5, 6: v = $urandom_range(MAX_KEYS - 1, 7);
            default: v = $urandom_range(6, 2);
        endcase
        set_key_count(v);
        load_track(key_limit, $urandom_range(9) == 0);
        if (long_hold) hold_requests++;
        repeat ($urandom_range(20, 6)) begin
            if ($urandom_range(15) == 0) begin
                write_key(6'($urandom), $urandom, key_value(), key_value(), key_value());
            end else begin
                random_query();
            end
        end
    endtask

    initial begin : stimulus
        int target;
        int wait_cycles;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single key, reset key count
        write_key(6'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
        // key count of zero acts as one
        set_key_count(0);
        query_at(32'h1234_5678);
        // three keys with extreme values and a track ending at the top time
        write_key(6'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        write_key(6'd1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        write_key(6'd2, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_8000, 32'hFFFF_0000);
        set_key_count(3);
        query_at(32'h0000_0000);
        query_at(32'h0001_0000);
        query_at(32'h0001_8000);
        query_at(32'h0001_FFFF);
        query_at(32'h0002_0000);
        query_at(32'h8000_0000);
        query_at(32'hFFFF_FFFF);
        // past the end of the track, and exactly on the last key
        write_key(6'd2, 32'h0003_0000, 32'h0000_0000, 32'h0001_8000, 32'hFFFF_0000);
        query_at(32'hFFFF_FFFF);
        query_at(32'h0003_0000);
        // two keys at the same time
        write_key(6'd1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        query_at(32'h0001_0000);
        query_at(32'h0002_0000);

        // fill every slot before random traffic
        set_key_count(127);
        load_track(MAX_KEYS, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 72; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 72; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            run_round(1'b1);
            while (items_sent < target) run_round(1'b0);
        end

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (results_outstanding != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (END_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
